// ===== rtl/tbps_pkg.sv =====
// Shared types and constants of the transfer buffer pool scheduler.
`default_nettype none
package tbps_pkg;

   localparam int POOL_MAX_DEFAULT  = 16;
   localparam int SEQ_BITS_DEFAULT  = 32;
   localparam int SPARE_BUFFERS     = 2;
   localparam int DEFAULT_SUBMITTED = 4;
   localparam int UNDERFLOW_BITS    = 32;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_FILL     = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_STOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CS_COMPLETED = 2'd0,
      CS_CANCELLED = 2'd1,
      CS_FAILED    = 2'd2
   } completion_type;

   typedef enum logic [1:0] {
      ST_EMPTY     = 2'd0,
      ST_SUBMITTED = 2'd1,
      ST_FILLED    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACT_INACTIVE  = 2'd0,
      ACT_CANCELING = 2'd1,
      ACT_RUNNING   = 2'd2
   } activity_type;

   typedef enum logic [2:0] {
      CMD_START,
      CMD_FILL,
      CMD_COMPLETE,
      CMD_FAIL,
      CMD_STOP,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FILL,
      BK_OLDEST,
      BK_DRAIN
   } back_state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] buffer_index;
      logic [1:0] completion_status;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        granted;
      logic [3:0]  chosen_index;
      logic        submit;
      logic        underflow;
      logic [31:0] underflow_total;
      logic [1:0]  run_status;
      logic        lost;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   buffer_index;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/tbps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tbps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/tbps_front.sv =====
// Front end: accepts request beats, classifies them and queues commands.
`default_nettype none
module tbps_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tbps_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_pop,
   output tbps_pkg::cmd_type     cmd_data
);

   localparam int PTR_W = $clog2(tbps_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tbps_pkg::QUEUE_DEPTH + 1);

   tbps_pkg::cmd_type q_ff [tbps_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;
   tbps_pkg::cmd_type cmd_new;

   always_comb begin
      cmd_new.buffer_index = req_data.buffer_index;
      unique case (tbps_pkg::op_type'(req_data.operation))
         tbps_pkg::OP_START: cmd_new.kind = tbps_pkg::CMD_START;
         tbps_pkg::OP_FILL:  cmd_new.kind = tbps_pkg::CMD_FILL;
         tbps_pkg::OP_STOP:  cmd_new.kind = tbps_pkg::CMD_STOP;
         default: begin
            case (req_data.completion_status)
               tbps_pkg::CS_COMPLETED: cmd_new.kind = tbps_pkg::CMD_COMPLETE;
               tbps_pkg::CS_CANCELLED: cmd_new.kind = tbps_pkg::CMD_NOP;
               default:                cmd_new.kind = tbps_pkg::CMD_FAIL;
            endcase
         end
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(tbps_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tbps_back.sv =====
// Back end: executes queued commands over the buffer pool, one entry a cycle.
`default_nettype none
module tbps_back #(
   parameter int POOL_MAX = tbps_pkg::POOL_MAX_DEFAULT,
   parameter int SEQ_BITS = tbps_pkg::SEQ_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_pop,
   input  wire tbps_pkg::cmd_type cmd_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tbps_pkg::rsp_type      rsp_data
);

   localparam int IDX_W      = $clog2(POOL_MAX);
   localparam int PW         = $clog2(POOL_MAX + 1);
   localparam int MAX_SUB    = POOL_MAX - tbps_pkg::SPARE_BUFFERS;
   localparam int POOL_RESET = (tbps_pkg::DEFAULT_SUBMITTED + tbps_pkg::SPARE_BUFFERS
                                > POOL_MAX) ? POOL_MAX
                               : tbps_pkg::DEFAULT_SUBMITTED + tbps_pkg::SPARE_BUFFERS;

   tbps_pkg::back_state_type state_ff, state_in;
   tbps_pkg::status_type     status_ff [POOL_MAX];
   tbps_pkg::status_type     status_in [POOL_MAX];
   tbps_pkg::activity_type   activity_ff, activity_in;
   logic [3:0]               sub_count_ff;
   logic [PW-1:0]            pool_ff, pool_in;
   logic [SEQ_BITS-1:0]      next_seq_ff, next_seq_in;
   logic [tbps_pkg::UNDERFLOW_BITS-1:0] under_cnt_ff, under_cnt_in;
   logic                     lost_ff, lost_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         cur_idx_ff, cur_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         best_ff, best_in;
   logic [SEQ_BITS-1:0]      best_seq_ff, best_seq_in;
   logic                     p_valid_ff, p_valid_in;
   logic                     p_filled_ff, p_filled_in;
   logic [IDX_W-1:0]         p_idx_ff, p_idx_in;
   logic                     rsp_valid_ff;
   tbps_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_load;
   logic                     ram_we;
   logic [SEQ_BITS-1:0]      ram_rdata;
   logic                     cmp_found;
   logic [IDX_W-1:0]         cmp_best;
   logic [SEQ_BITS-1:0]      cmp_seq;
   logic                     scan_last;
   logic                     slot_free;
   logic [3:0]               start_cnt;
   logic [PW-1:0]            start_n;

   function automatic logic [3:0] to_nibble(input logic [IDX_W-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[3:0];
   endfunction

   function automatic tbps_pkg::activity_type stop_next(input tbps_pkg::activity_type a);
      tbps_pkg::activity_type r;
      r = (a == tbps_pkg::ACT_RUNNING) ? tbps_pkg::ACT_CANCELING : tbps_pkg::ACT_INACTIVE;
      return r;
   endfunction

   tbps_ram #(
      .WIDTH (SEQ_BITS),
      .DEPTH (POOL_MAX)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (scan_ff),
      .wr_data (next_seq_ff),
      .rd_addr (scan_ff),
      .rd_data (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign scan_last = (32'(scan_ff) == 32'(pool_ff) - 32'd1);

   always_comb begin
      start_cnt = (sub_count_ff == 4'd0) ? 4'(tbps_pkg::DEFAULT_SUBMITTED) : sub_count_ff;
      start_n   = (32'(start_cnt) > MAX_SUB) ? PW'(MAX_SUB) : PW'(start_cnt);
   end

   always_comb begin
      cmp_found = found_ff;
      cmp_best  = best_ff;
      cmp_seq   = best_seq_ff;
      if (p_valid_ff && p_filled_ff && (!found_ff || ram_rdata < best_seq_ff)) begin
         cmp_found = 1'b1;
         cmp_best  = p_idx_ff;
         cmp_seq   = ram_rdata;
      end
   end

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      activity_in = activity_ff;
      pool_in     = pool_ff;
      next_seq_in = next_seq_ff;
      under_cnt_in = under_cnt_ff;
      lost_in     = lost_ff;
      scan_in     = scan_ff;
      cur_idx_in  = cur_idx_ff;
      found_in    = cmp_found;
      best_in     = cmp_best;
      best_seq_in = cmp_seq;
      p_valid_in  = 1'b0;
      p_filled_in = (status_ff[scan_ff] == tbps_pkg::ST_FILLED);
      p_idx_in    = scan_ff;
      cmd_pop     = 1'b0;
      ram_we      = 1'b0;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      rsp_in.accepted = 1'b1;

      unique case (state_ff)
         tbps_pkg::BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               case (cmd_data.kind)
                  tbps_pkg::CMD_START: begin
                     for (int i = 0; i < POOL_MAX; i++) begin
                        status_in[i] = (i < 32'(start_n)) ? tbps_pkg::ST_SUBMITTED
                                                          : tbps_pkg::ST_EMPTY;
                     end
                     pool_in     = start_n + PW'(tbps_pkg::SPARE_BUFFERS);
                     next_seq_in = '0;
                     activity_in = tbps_pkg::ACT_RUNNING;
                     rsp_load    = 1'b1;
                  end
                  tbps_pkg::CMD_FILL: begin
                     if (activity_ff == tbps_pkg::ACT_RUNNING) begin
                        scan_in  = '0;
                        state_in = tbps_pkg::BK_FILL;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  tbps_pkg::CMD_COMPLETE: begin
                     if (activity_ff == tbps_pkg::ACT_RUNNING &&
                         32'(cmd_data.buffer_index) < 32'(pool_ff)) begin
                        scan_in    = '0;
                        found_in   = 1'b0;
                        cur_idx_in = IDX_W'(cmd_data.buffer_index);
                        state_in   = tbps_pkg::BK_OLDEST;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  tbps_pkg::CMD_FAIL: begin
                     lost_in     = 1'b1;
                     activity_in = stop_next(activity_ff);
                     rsp_load    = 1'b1;
                  end
                  tbps_pkg::CMD_STOP: begin
                     if (activity_ff == tbps_pkg::ACT_INACTIVE) begin
                        rsp_in.accepted = 1'b0;
                     end else begin
                        activity_in = stop_next(activity_ff);
                     end
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         tbps_pkg::BK_FILL: begin
            if (status_ff[scan_ff] == tbps_pkg::ST_EMPTY) begin
               status_in[scan_ff]  = tbps_pkg::ST_FILLED;
               ram_we              = 1'b1;
               next_seq_in         = next_seq_ff + SEQ_BITS'(1);
               rsp_in.granted      = 1'b1;
               rsp_in.chosen_index = to_nibble(scan_ff);
               rsp_load            = 1'b1;
               state_in            = tbps_pkg::BK_IDLE;
            end else if (scan_last) begin
               rsp_load = 1'b1;
               state_in = tbps_pkg::BK_IDLE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         tbps_pkg::BK_OLDEST: begin
            p_valid_in = 1'b1;
            if (scan_last) begin
               state_in = tbps_pkg::BK_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         tbps_pkg::BK_DRAIN: begin
            if (cmp_found) begin
               status_in[cmp_best]   = tbps_pkg::ST_SUBMITTED;
               status_in[cur_idx_ff] = tbps_pkg::ST_EMPTY;
               rsp_in.chosen_index   = to_nibble(cmp_best);
            end else begin
               rsp_in.chosen_index = to_nibble(cur_idx_ff);
               rsp_in.underflow    = 1'b1;
               under_cnt_in        = under_cnt_ff + 32'd1;
            end
            rsp_in.submit = 1'b1;
            rsp_load      = 1'b1;
            state_in      = tbps_pkg::BK_IDLE;
         end
         default: begin
            state_in = tbps_pkg::BK_IDLE;
         end
      endcase

      rsp_in.underflow_total = under_cnt_in;
      rsp_in.run_status      = activity_in;
      rsp_in.lost            = lost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbps_pkg::BK_IDLE;
         activity_ff  <= tbps_pkg::ACT_INACTIVE;
         sub_count_ff <= 4'(tbps_pkg::DEFAULT_SUBMITTED);
         pool_ff      <= PW'(POOL_RESET);
         next_seq_ff  <= '0;
         under_cnt_ff <= '0;
         lost_ff      <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < POOL_MAX; i++) begin
            status_ff[i] <= tbps_pkg::ST_EMPTY;
         end
      end else begin
         state_ff     <= state_in;
         activity_ff  <= activity_in;
         pool_ff      <= pool_in;
         next_seq_ff  <= next_seq_in;
         under_cnt_ff <= under_cnt_in;
         lost_ff      <= lost_in;
         p_valid_ff   <= p_valid_in;
         status_ff    <= status_in;
         if (csr_valid && csr_ready) begin
            sub_count_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      cur_idx_ff  <= cur_idx_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_seq_ff <= best_seq_in;
      p_filled_ff <= p_filled_in;
      p_idx_ff    <= p_idx_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/transfer_buffer_pool_scheduler_unit.sv =====
// Top level of the transfer buffer pool scheduler: front queue and back executor.
//
// Request beats (req_valid/req_stall/req_data) carry start, fill, completion
// and stop operations. Each beat gives exactly one response beat on
// rsp_valid/rsp_stall/rsp_data, in order. The single register, the number of
// buffers submitted at start, is written through csr_valid/csr_ready/csr_data.
// A two-entry command queue sits between the front and the back end, so
// request beats are taken while the back end works or a response waits.
// Start, stop, cancelled or failed completions, and fills or completions
// while not running, are answered straight from the idle state. A fill
// scans the pool for the lowest empty buffer, one entry a cycle. A good
// completion scans every entry of the pool through the sequence stamp RAM.
// The back end takes no new command until the current one is done.
// Reset is synchronous: the pool goes empty, the block inactive, counters
// cleared, the register back to 4. No clearing pass is needed.
// While a response is valid and rsp_stall is high, it is held and the back
// end takes no further command; the queue then fills and req_stall rises.
`default_nettype none
module transfer_buffer_pool_scheduler_unit #(
   parameter int POOL_MAX = tbps_pkg::POOL_MAX_DEFAULT,
   parameter int SEQ_BITS = tbps_pkg::SEQ_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tbps_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tbps_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   tbps_pkg::cmd_type cmd_data;

   tbps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   tbps_back #(
      .POOL_MAX (POOL_MAX),
      .SEQ_BITS (SEQ_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
